// ===== sv/bhu_pkg.sv =====
`timescale 1ns / 1ps

package bhu_pkg;

  localparam int MAX_BREAKPOINTS = 16;
  localparam int BP_IDX_W = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1;
  localparam int BP_CNT_W = $clog2(MAX_BREAKPOINTS + 1);
  localparam int ADDR_W   = 32;

  typedef enum logic [2:0] {
    CMD_CHECK  = 3'd0,
    CMD_SET    = 3'd1,
    CMD_STEP   = 3'd2,
    CMD_NEXT   = 3'd3,
    CMD_DETACH = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    WHY_NONE  = 2'd0,
    WHY_ENTRY = 2'd1,
    WHY_STEP  = 2'd2,
    WHY_BREAK = 2'd3
  } why_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_SH_RD,
    ST_SH_WR
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              once;
  } bp_entry_t;

  typedef struct packed {
    logic                en;
    logic [BP_IDX_W-1:0] addr;
    bp_entry_t           data;
  } tbl_wr_t;

endpackage

// ===== sv/breakpoint_halt_unit.sv =====
`timescale 1ns / 1ps

// debug halt unit: decides before each instruction whether execution stops,
// keeping an ordered breakpoint table of MAX_BREAKPOINTS entries (persistent
// or one-shot) in a single-port-read memory. set, step, next, detach and any
// check answered by the entry / step / detached flags or by an empty table
// give their result word in the cycle after accept. a check that has to
// search the table walks it with one shared 32-bit equality compare, each
// entry examined in a memory read state and then a compare state, stopping
// at the first match; a matched one-shot entry is then removed by moving
// each later entry down one slot, each move a read state then a write state.
// in_stall is high while a search or removal runs and while an undelivered
// result is held back by out_stall. code_length is written through the cfg
// port, which is always ready.
module breakpoint_halt_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_insn_idx,
  input  logic        in_is_call,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_halt,
  output logic [1:0]  out_halt_reason,
  output logic        out_status,
  // code_length register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int IW = bhu_pkg::BP_IDX_W;
  localparam int CW = bhu_pkg::BP_CNT_W;

  // sequencer and flag state
  bhu_pkg::state_t   state_r, state_nxt;
  logic              entry_seen_r, entry_seen_nxt;
  logic              step_pending_r, step_pending_nxt;
  logic              detached_r, detached_nxt;
  logic [CW-1:0]     bp_used_r, bp_used_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic [31:0]       where_r, where_nxt;
  logic [31:0]       code_length_r;

  // result word register
  logic              out_valid_r, out_valid_nxt;
  logic              halt_r, halt_nxt;
  bhu_pkg::why_t     why_r, why_nxt;
  logic              status_r, status_nxt;

  // table access
  bhu_pkg::tbl_wr_t   tbl_wr;
  bhu_pkg::bp_entry_t tbl_rd;
  logic [IW-1:0]      tbl_rd_addr;

  logic              accept;
  logic              tbl_full;
  logic              next_in_range;
  logic              hit;
  logic [CW-1:0]     ptr_inc;
  logic              ptr_inc_last;
  bhu_pkg::cmd_t     cmd;

  assign cmd       = bhu_pkg::cmd_t'(in_cmd);
  assign in_stall  = (state_r != bhu_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign tbl_full      = (bp_used_r == CW'(bhu_pkg::MAX_BREAKPOINTS));
  // insn_idx + 1 < code_length with no wrap
  assign next_in_range = ({1'b0, in_insn_idx} + 33'd1) < {1'b0, code_length_r};

  // the shared compare unit used by every compare step of the search
  assign hit          = (tbl_rd.addr == where_r);
  assign ptr_inc      = ptr_r + CW'(1);
  assign ptr_inc_last = (ptr_inc >= bp_used_r);
  assign tbl_rd_addr  = ptr_r[IW-1:0];

  bhu_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= bhu_pkg::ST_IDLE;
      entry_seen_r   <= 1'b0;
      step_pending_r <= 1'b0;
      detached_r     <= 1'b0;
      bp_used_r      <= '0;
      ptr_r          <= '0;
      out_valid_r    <= 1'b0;
      code_length_r  <= '0;
    end else begin
      state_r        <= state_nxt;
      entry_seen_r   <= entry_seen_nxt;
      step_pending_r <= step_pending_nxt;
      detached_r     <= detached_nxt;
      bp_used_r      <= bp_used_nxt;
      ptr_r          <= ptr_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        code_length_r <= cfg_data;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    where_r  <= where_nxt;
    halt_r   <= halt_nxt;
    why_r    <= why_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    entry_seen_nxt   = entry_seen_r;
    step_pending_nxt = step_pending_r;
    detached_nxt     = detached_r;
    bp_used_nxt      = bp_used_r;
    ptr_nxt          = ptr_r;
    where_nxt        = where_r;
    out_valid_nxt    = out_valid_r && out_stall;
    halt_nxt         = halt_r;
    why_nxt          = why_r;
    status_nxt       = status_r;
    tbl_wr.en        = 1'b0;
    tbl_wr.addr      = bp_used_r[IW-1:0];
    tbl_wr.data.addr = in_insn_idx;
    tbl_wr.data.once = 1'b0;

    unique case (state_r)
      bhu_pkg::ST_IDLE: begin
        if (accept) begin
          // default answer: nothing halts, status ok
          out_valid_nxt = 1'b1;
          halt_nxt      = 1'b0;
          why_nxt       = bhu_pkg::WHY_NONE;
          status_nxt    = 1'b0;
          case (cmd)
            bhu_pkg::CMD_CHECK: begin
              if (detached_r) begin
                // never halts
              end else if (!entry_seen_r) begin
                entry_seen_nxt = 1'b1;
                halt_nxt       = 1'b1;
                why_nxt        = bhu_pkg::WHY_ENTRY;
              end else if (step_pending_r) begin
                step_pending_nxt = 1'b0;
                halt_nxt         = 1'b1;
                why_nxt          = bhu_pkg::WHY_STEP;
              end else if (bp_used_r != '0) begin
                // search the table, result comes at the end
                out_valid_nxt = 1'b0;
                where_nxt     = in_insn_idx;
                ptr_nxt       = '0;
                state_nxt     = bhu_pkg::ST_RD;
              end
            end
            bhu_pkg::CMD_SET: begin
              if (tbl_full) begin
                status_nxt = 1'b1;
              end else begin
                tbl_wr.en   = 1'b1;
                bp_used_nxt = bp_used_r + CW'(1);
              end
            end
            bhu_pkg::CMD_STEP: begin
              step_pending_nxt = 1'b1;
            end
            bhu_pkg::CMD_NEXT: begin
              if (in_is_call && next_in_range) begin
                // one-shot just past the call; a full table refuses it
                if (tbl_full) begin
                  status_nxt = 1'b1;
                end else begin
                  tbl_wr.en        = 1'b1;
                  tbl_wr.data.addr = in_insn_idx + 32'd1;
                  tbl_wr.data.once = 1'b1;
                  bp_used_nxt      = bp_used_r + CW'(1);
                end
              end else begin
                step_pending_nxt = 1'b1;
              end
            end
            bhu_pkg::CMD_DETACH: begin
              detached_nxt = 1'b1;
            end
            default: begin
              // unknown command, all-zero answer
            end
          endcase
        end
      end

      bhu_pkg::ST_RD: begin
        // entry at ptr is being read
        state_nxt = bhu_pkg::ST_CMP;
      end

      bhu_pkg::ST_CMP: begin
        if (hit) begin
          halt_nxt = 1'b1;
          why_nxt  = bhu_pkg::WHY_BREAK;
          status_nxt = 1'b0;
          if (tbl_rd.once) begin
            // drop this entry, compacting the ones after it
            if (ptr_inc_last) begin
              bp_used_nxt   = bp_used_r - CW'(1);
              out_valid_nxt = 1'b1;
              state_nxt     = bhu_pkg::ST_IDLE;
            end else begin
              ptr_nxt   = ptr_inc;
              state_nxt = bhu_pkg::ST_SH_RD;
            end
          end else begin
            out_valid_nxt = 1'b1;
            state_nxt     = bhu_pkg::ST_IDLE;
          end
        end else if (ptr_inc_last) begin
          halt_nxt      = 1'b0;
          why_nxt       = bhu_pkg::WHY_NONE;
          status_nxt    = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = bhu_pkg::ST_IDLE;
        end else begin
          ptr_nxt   = ptr_inc;
          state_nxt = bhu_pkg::ST_RD;
        end
      end

      bhu_pkg::ST_SH_RD: begin
        state_nxt = bhu_pkg::ST_SH_WR;
      end

      bhu_pkg::ST_SH_WR: begin
        // move entry ptr down to ptr - 1
        tbl_wr.en   = 1'b1;
        tbl_wr.addr = IW'(ptr_r - CW'(1));
        tbl_wr.data = tbl_rd;
        if (ptr_inc_last) begin
          bp_used_nxt   = bp_used_r - CW'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = bhu_pkg::ST_IDLE;
        end else begin
          ptr_nxt   = ptr_inc;
          state_nxt = bhu_pkg::ST_SH_RD;
        end
      end

      default: begin
        state_nxt = bhu_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_halt        = halt_r;
  assign out_halt_reason = why_r;
  assign out_status      = status_r;

endmodule

// ===== sv/bhu_table.sv =====
`timescale 1ns / 1ps

module bhu_table (
  input  logic                         clk,
  input  bhu_pkg::tbl_wr_t             wr,
  input  logic [bhu_pkg::BP_IDX_W-1:0] rd_addr,
  output bhu_pkg::bp_entry_t           rd_data
);

  bhu_pkg::bp_entry_t mem [bhu_pkg::MAX_BREAKPOINTS];
  bhu_pkg::bp_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/bhu_checker.sv =====
`timescale 1ns / 1ps

module bhu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  in_cmd,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_halt,
  input logic [1:0]  out_halt_reason,
  input logic        out_status
);

  // held result word does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_halt)
      && $stable(out_halt_reason) && $stable(out_status))
    else $error("result word changed while stalled");

  // halt flag and reason agree
  a_halt_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_halt == (out_halt_reason != 2'd0)))
    else $error("halt and halt_reason disagree");

  // a halting word never reports a refused add
  a_halt_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_halt |-> !out_status)
    else $error("halt with nonzero status");

  // non-check commands answer in the next cycle without halting
  a_cmd_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_cmd != bhu_pkg::CMD_CHECK)
      |=> out_valid && !out_halt)
    else $error("non-check command missed its one-cycle answer");

endmodule

bind breakpoint_halt_unit bhu_checker u_bhu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_cmd          (in_cmd),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_halt        (out_halt),
  .out_halt_reason (out_halt_reason),
  .out_status      (out_status)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_HALF      = 4;
  // longest search plus one-shot removal, with margin
  localparam int SETTLE_CYCLES = 4 * bhu_pkg::MAX_BREAKPOINTS + 16;
  localparam int QUIET_LIMIT   = 4000;
  // keep persistent entries below the table size so that random traffic never
  // locks the table full for good
  localparam int PERSIST_CAP   = 11;
  localparam int RANDOM_WORDS  = 440;
  localparam int PRINT_CAP     = 50;

  typedef struct {
    logic          halt;
    bhu_pkg::why_t reason;
    logic          status;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_cmd = 3'd0;
  logic [31:0] in_insn_idx = 32'd0;
  logic        in_is_call = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_halt;
  logic [1:0]  out_halt_reason;
  logic        out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = 32'd0;

  // predicted state of the halt unit
  logic        seen_entry = 1'b0;
  logic        step_armed = 1'b0;
  logic        unit_detached = 1'b0;
  logic [31:0] code_len = 32'd0;
  logic [31:0] bp_addr_q[$];
  logic        bp_once_q[$];

  verdict_t    verdict_q[$];
  verdict_t    head_v;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  breakpoint_halt_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_insn_idx     (in_insn_idx),
    .in_is_call      (in_is_call),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_halt        (out_halt),
    .out_halt_reason (out_halt_reason),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic table_insert(logic [31:0] where, logic once);
    if (bp_addr_q.size() >= bhu_pkg::MAX_BREAKPOINTS) return 1'b1;
    bp_addr_q.push_back(where);
    bp_once_q.push_back(once);
    return 1'b0;
  endfunction

  // applies one command to the predicted state and returns the answer word
  function automatic verdict_t predict_halt(logic [2:0] cmd, logic [31:0] idx, logic call);
    verdict_t v;
    int       hit;
    v.halt   = 1'b0;
    v.reason = bhu_pkg::WHY_NONE;
    v.status = 1'b0;
    hit      = -1;
    case (cmd)
      bhu_pkg::CMD_CHECK: begin
        if (unit_detached) begin
          v.reason = bhu_pkg::WHY_NONE;
        end else if (!seen_entry) begin
          seen_entry = 1'b1;
          v.reason   = bhu_pkg::WHY_ENTRY;
        end else if (step_armed) begin
          step_armed = 1'b0;
          v.reason   = bhu_pkg::WHY_STEP;
        end else begin
          // earliest matching entry wins
          for (int k = 0; k < bp_addr_q.size(); k++) begin
            if (hit < 0 && bp_addr_q[k] == idx) hit = k;
          end
          if (hit >= 0) begin
            v.reason = bhu_pkg::WHY_BREAK;
            if (bp_once_q[hit]) begin
              bp_addr_q.delete(hit);
              bp_once_q.delete(hit);
            end
          end
        end
      end
      bhu_pkg::CMD_SET: v.status = table_insert(idx, 1'b0);
      bhu_pkg::CMD_STEP: step_armed = 1'b1;
      bhu_pkg::CMD_NEXT: begin
        // bound compared at 33 bits so that idx + 1 cannot wrap
        if (call && ({1'b0, idx} + 33'd1 < {1'b0, code_len}))
          v.status = table_insert(idx + 32'd1, 1'b1);
        else
          step_armed = 1'b1;
      end
      bhu_pkg::CMD_DETACH: unit_detached = 1'b1;
      default: ;
    endcase
    v.halt = (v.reason != bhu_pkg::WHY_NONE);
    return v;
  endfunction

  function automatic int persistent_count();
    int n;
    n = 0;
    foreach (bp_once_q[k]) if (!bp_once_q[k]) n++;
    return n;
  endfunction

  function automatic int one_shot_slot();
    int slot;
    slot = -1;
    foreach (bp_once_q[k]) if (slot < 0 && bp_once_q[k]) slot = k;
    return slot;
  endfunction

  // mostly a small set of indexes so that checks hit the table
  function automatic logic [31:0] pick_index();
    if ($urandom_range(0, 9) != 0) return $urandom_range(0, 25);
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers, result checker, watchdog
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    if (mismatch_count < PRINT_CAP) $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // sends one command word; the answer is predicted at the accepting edge
  task automatic send_word(logic [2:0] cmd, logic [31:0] idx, logic call);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_insn_idx <= idx;
    in_is_call  <= call;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    verdict_q.push_back(predict_halt(cmd, idx, call));
  endtask

  // all answers back, then let a trailing one-shot removal finish
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_code_length(logic [31:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    code_len = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        head_v = verdict_q.pop_front();
        if (out_halt !== head_v.halt)
          report_mismatch($sformatf("halt %b, expected %b", out_halt, head_v.halt));
        if (out_halt_reason !== head_v.reason)
          report_mismatch($sformatf("halt_reason %0d, expected %0d",
                                    out_halt_reason, head_v.reason));
        if (out_status !== head_v.status)
          report_mismatch($sformatf("status %b, expected %b", out_status, head_v.status));
      end
    end
  end

  // ends the run when no handshake completes for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // entry halt on the first check, step halts, next with a zero program length
  task automatic test_entry_and_step();
    write_code_length(32'd0);
    send_word(bhu_pkg::CMD_CHECK, 32'd5, 1'b0);
    send_word(bhu_pkg::CMD_CHECK, 32'd5, 1'b0);
    send_word(bhu_pkg::CMD_STEP, 32'hFFFF_FFFF, 1'b1);
    send_word(bhu_pkg::CMD_CHECK, 32'd5, 1'b0);
    send_word(bhu_pkg::CMD_NEXT, 32'd3, 1'b1);
    send_word(bhu_pkg::CMD_CHECK, 32'd3, 1'b0);
  endtask

  // persistent hits at both ends of the index range, one-shot ahead of a duplicate
  task automatic test_breakpoints();
    write_code_length(32'hFFFF_FFFF);
    send_word(bhu_pkg::CMD_SET, 32'hFFFF_FFFF, 1'b0);
    send_word(bhu_pkg::CMD_CHECK, 32'hFFFF_FFFF, 1'b0);
    send_word(bhu_pkg::CMD_SET, 32'd0, 1'b1);
    send_word(bhu_pkg::CMD_CHECK, 32'd0, 1'b0);
    send_word(bhu_pkg::CMD_CHECK, 32'd0, 1'b0);
    send_word(bhu_pkg::CMD_NEXT, 32'd8, 1'b1);
    send_word(bhu_pkg::CMD_SET, 32'd9, 1'b0);
    send_word(bhu_pkg::CMD_CHECK, 32'd9, 1'b0);
    send_word(bhu_pkg::CMD_CHECK, 32'd9, 1'b0);
  endtask

  // next at the top of the range, past the end, and without a call
  task automatic test_next_bounds();
    send_word(bhu_pkg::CMD_NEXT, 32'hFFFF_FFFE, 1'b1);
    send_word(bhu_pkg::CMD_CHECK, 32'd1, 1'b0);
    send_word(bhu_pkg::CMD_NEXT, 32'hFFFF_FFFF, 1'b1);
    send_word(bhu_pkg::CMD_CHECK, 32'd2, 1'b0);
    send_word(bhu_pkg::CMD_NEXT, 32'd20, 1'b0);
    send_word(bhu_pkg::CMD_CHECK, 32'd20, 1'b0);
    send_word(bhu_pkg::CMD_NEXT, 32'hFFFF_FFFD, 1'b1);
    send_word(bhu_pkg::CMD_CHECK, 32'hFFFF_FFFE, 1'b0);
  endtask

  task automatic test_unknown_commands();
    for (int c = int'(bhu_pkg::CMD_DETACH) + 1; c < 8; c++)
      send_word(3'(c), 32'hFFFF_FFFF, 1'b1);
  endtask

  // fill with one-shots, see set and next refused, then hit each one-shot away
  task automatic test_table_full();
    int tries;
    tries = 0;
    write_code_length(32'hFFFF_FFFF);
    if (step_armed) send_word(bhu_pkg::CMD_CHECK, 32'd0, 1'b0);
    while (bp_addr_q.size() < bhu_pkg::MAX_BREAKPOINTS)
      send_word(bhu_pkg::CMD_NEXT, $urandom_range(1000, 1100), 1'b1);
    send_word(bhu_pkg::CMD_SET, $urandom, 1'($urandom_range(0, 1)));
    send_word(bhu_pkg::CMD_NEXT, $urandom_range(1000, 1100), 1'b1);
    // a refused next must not leave a step behind
    send_word(bhu_pkg::CMD_CHECK, 32'd500, 1'b0);
    while (one_shot_slot() >= 0 && tries < 40) begin
      send_word(bhu_pkg::CMD_CHECK, bp_addr_q[one_shot_slot()], 1'b0);
      tries++;
    end
  endtask

  // mostly checks and next-over-call, on indexes drawn mostly from a small set
  task automatic test_random_traffic(logic [31:0] len, int send_pct, int recv_pct);
    int          r;
    logic [2:0]  cmd;
    logic [31:0] idx;
    logic        call;
    write_code_length(len);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (RANDOM_WORDS) begin
      r    = $urandom_range(0, 99);
      idx  = pick_index();
      call = 1'($urandom_range(0, 1));
      if (r < 42) begin
        cmd = bhu_pkg::CMD_CHECK;
      end else if (r < 67) begin
        cmd  = bhu_pkg::CMD_NEXT;
        call = ($urandom_range(0, 9) < 8);
      end else if (r < 75) begin
        cmd = bhu_pkg::CMD_STEP;
        idx = $urandom;
      end else if (r < 83) begin
        cmd = (persistent_count() < PERSIST_CAP) ? bhu_pkg::CMD_SET : bhu_pkg::CMD_NEXT;
      end else if (r < 88) begin
        cmd = 3'($urandom_range(int'(bhu_pkg::CMD_DETACH) + 1, 7));
        idx = $urandom;
      end else begin
        cmd = bhu_pkg::CMD_CHECK;
        idx = $urandom;
      end
      send_word(cmd, idx, call);
    end
  endtask

  // once detached no check halts, the other commands still act
  task automatic test_detached();
    write_code_length(32'd16);
    send_word(bhu_pkg::CMD_DETACH, $urandom, 1'($urandom_range(0, 1)));
    repeat (60) send_word(3'($urandom_range(0, int'(bhu_pkg::CMD_DETACH))), pick_index(),
                          1'($urandom_range(0, 1)));
    send_word(bhu_pkg::CMD_CHECK, 32'd0, 1'b0);
  endtask

  initial begin
    send_idle_pct = 26;
    recv_idle_pct = 56;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_entry_and_step();
    test_breakpoints();
    test_next_bounds();
    test_unknown_commands();
    test_table_full();
    test_random_traffic(32'd24, 26, 56);
    test_random_traffic(32'd13, 56, 26);
    test_random_traffic(32'hFFFF_FFFF, 0, 0);
    test_detached();

    wait_idle();
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
